// ----- hw/rtl/euler_angles_to_local_axes_defines.svh -----
// Assertion helpers used by the top-level RTL.
`ifndef EULER_ANGLES_TO_LOCAL_AXES_DEFINES_SVH
`define EULER_ANGLES_TO_LOCAL_AXES_DEFINES_SVH

// Same-cycle implication under synchronous reset.
`define EAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under synchronous reset.
`define EAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/eal_pkg.sv -----
package eal_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W = 5;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam int AXIS_W = 16;

  typedef struct packed {
    logic signed [31:0] sin;
    logic signed [31:0] cos;
  } sincos_t;

  function automatic logic signed [31:0] atan_turn32(input logic [STEP_W-1:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:  v = 32'sd536870912;
      5'd1:  v = 32'sd316933406;
      5'd2:  v = 32'sd167458907;
      5'd3:  v = 32'sd85004756;
      5'd4:  v = 32'sd42667331;
      5'd5:  v = 32'sd21354465;
      5'd6:  v = 32'sd10679838;
      5'd7:  v = 32'sd5340245;
      5'd8:  v = 32'sd2670163;
      5'd9:  v = 32'sd1335087;
      5'd10: v = 32'sd667544;
      5'd11: v = 32'sd333772;
      5'd12: v = 32'sd166886;
      5'd13: v = 32'sd83443;
      5'd14: v = 32'sd41722;
      5'd15: v = 32'sd20861;
      5'd16: v = 32'sd10430;
      5'd17: v = 32'sd5215;
      5'd18: v = 32'sd2608;
      5'd19: v = 32'sd1304;
      5'd20: v = 32'sd652;
      5'd21: v = 32'sd326;
      5'd22: v = 32'sd163;
      5'd23: v = 32'sd81;
      5'd24: v = 32'sd41;
      5'd25: v = 32'sd20;
      5'd26: v = 32'sd10;
      5'd27: v = 32'sd5;
      5'd28: v = 32'sd3;
      5'd29: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/eal_cordic.sv -----
module eal_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [ANGLE_BITS-1:0] angle,
  output logic                  done,
  output eal_pkg::sincos_t      sc
);
  import eal_pkg::*;

  logic signed [31:0] x_r, y_r, z_r;
  logic signed [31:0] x_nxt, y_nxt, z_nxt;
  logic [1:0]         quad_r;
  logic [STEP_W-1:0]  step_r;
  logic               busy_r, done_r;
  logic [31:0]        t;
  logic signed [31:0] dx, dy;

  assign t  = 32'(angle) << (32 - ANGLE_BITS);
  assign dx = y_r >>> step_r;
  assign dy = x_r >>> step_r;

  always_comb begin
    if (!z_r[31]) begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - atan_turn32(step_r);
    end else begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + atan_turn32(step_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= {2'b00, t[29:0]};
      quad_r <= t[31:30];
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  always_comb begin
    case (quad_r)
      2'd0:    begin sc.cos = x_r;  sc.sin = y_r;  end
      2'd1:    begin sc.cos = -y_r; sc.sin = x_r;  end
      2'd2:    begin sc.cos = -x_r; sc.sin = -y_r; end
      default: begin sc.cos = y_r;  sc.sin = -x_r; end
    endcase
  end

  assign done = done_r;

endmodule

// ----- hw/rtl/eal_merge.sv -----
module eal_merge #(
  parameter int AXIS_FRAC_BITS = 14
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  eal_pkg::sincos_t                           yaw_sc,
  input  eal_pkg::sincos_t                           pitch_sc,
  input  eal_pkg::sincos_t                           roll_sc,
  output logic                                       done,
  output logic [9*eal_pkg::AXIS_W-1:0]               axes
);
  import eal_pkg::*;

  localparam int SHIFT = 30 - AXIS_FRAC_BITS;
  localparam logic signed [33:0] HALF = (SHIFT > 0) ? (34'sd1 <<< (SHIFT - 1)) : 34'sd0;
  localparam logic signed [33:0] LIM  = 34'sd1 <<< AXIS_FRAC_BITS;
  localparam int NPROD = 14;
  localparam logic [3:0] DST_SPSR = 4'd9;
  localparam logic [3:0] DST_SPCR = 4'd10;
  localparam logic [3:0] DST_NONE = 4'd15;

  logic [3:0]         step_r;
  logic               busy_r, done_r;
  logic signed [31:0] opa, opb;
  logic [3:0]         dst;
  logic               neg;
  logic signed [63:0] prod_r;
  logic [3:0]         dst_r;
  logic               neg_r;
  logic signed [31:0] spsr_r, spcr_r;
  logic signed [33:0] acc_r [9];
  logic signed [33:0] term;
  logic signed [63:0] prod_rnd;
  logic [AXIS_W-1:0]  axis_r [9];
  logic [AXIS_W-1:0]  axis_nxt [9];

  always_comb begin
    opa = yaw_sc.cos;
    opb = roll_sc.cos;
    dst = DST_NONE;
    neg = 1'b0;
    case (step_r)
      4'd0:  begin opa = pitch_sc.sin; opb = roll_sc.sin;  dst = DST_SPSR; end
      4'd1:  begin opa = pitch_sc.sin; opb = roll_sc.cos;  dst = DST_SPCR; end
      4'd2:  begin opa = yaw_sc.cos;   opb = roll_sc.cos;  dst = 4'd0; end
      4'd3:  begin opa = yaw_sc.sin;   opb = spsr_r;       dst = 4'd0; end
      4'd4:  begin opa = yaw_sc.sin;   opb = roll_sc.cos;  dst = 4'd2; neg = 1'b1; end
      4'd5:  begin opa = yaw_sc.cos;   opb = spsr_r;       dst = 4'd2; end
      4'd6:  begin opa = yaw_sc.cos;   opb = roll_sc.sin;  dst = 4'd3; neg = 1'b1; end
      4'd7:  begin opa = yaw_sc.sin;   opb = spcr_r;       dst = 4'd3; end
      4'd8:  begin opa = pitch_sc.cos; opb = roll_sc.sin;  dst = 4'd1; end
      4'd9:  begin opa = pitch_sc.cos; opb = roll_sc.cos;  dst = 4'd4; end
      4'd10: begin opa = yaw_sc.sin;   opb = roll_sc.sin;  dst = 4'd5; end
      4'd11: begin opa = yaw_sc.cos;   opb = spcr_r;       dst = 4'd5; end
      4'd12: begin opa = yaw_sc.sin;   opb = pitch_sc.cos; dst = 4'd6; end
      4'd13: begin opa = yaw_sc.cos;   opb = pitch_sc.cos; dst = 4'd8; end
      default: begin dst = DST_NONE; end
    endcase
  end

  assign prod_rnd = (prod_r + 64'sd536870912) >>> 30;
  assign term     = neg_r ? -prod_rnd[33:0] : prod_rnd[33:0];

  always_comb begin
    logic signed [33:0] v;
    logic signed [33:0] r;
    for (int k = 0; k < 9; k++) begin
      v = (k == 7) ? -34'(pitch_sc.sin) : acc_r[k];
      r = (v + HALF) >>> SHIFT;
      if (r > LIM) r = LIM;
      if (r < -LIM) r = -LIM;
      axis_nxt[k] = r[AXIS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
      dst_r  <= DST_NONE;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        dst_r  <= DST_NONE;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        dst_r  <= dst;
        if (step_r == 4'(NPROD + 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(opa) * 64'(opb);
    neg_r  <= neg;
    if (start) begin
      for (int k = 0; k < 9; k++) acc_r[k] <= '0;
    end else if (busy_r) begin
      if (dst_r == DST_SPSR) spsr_r <= prod_rnd[31:0];
      else if (dst_r == DST_SPCR) spcr_r <= prod_rnd[31:0];
      else if (dst_r < 4'd9) acc_r[dst_r] <= acc_r[dst_r] + term;
      if (step_r == 4'(NPROD + 1)) begin
        for (int k = 0; k < 9; k++) axis_r[k] <= axis_nxt[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) axes[k*AXIS_W +: AXIS_W] = axis_r[k];
  end

  assign done = done_r;

endmodule

// ----- hw/rtl/euler_angles_to_local_axes.sv -----
// Flow: an accepted request starts the 30-step CORDIC in three parallel lanes; when the
// lanes finish, the merge runs, and its result is registered into out_tdata/out_tvalid.
// One request at a time: in_tready is high only when idle, as the CORDIC loop and the
// single shared 32x32 multiplier are reused; a stalled result holds the input.
// Reset: synchronous active-low rst_n clears the angle stores to zero and
// empties the pipeline; payload registers are not reset.
`include "euler_angles_to_local_axes_defines.svh"

module euler_angles_to_local_axes #(
  parameter int ANGLE_BITS     = 16,
  parameter int AXIS_FRAC_BITS = 14
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [47:0]   in_tdata,   // yaw_angle, pitch_angle, roll_angle
  input  logic          in_tuser,   // command
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [143:0]  out_tdata   // right_x/y/z, up_x/y/z, forward_x/y/z
);
  import eal_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CORD  = 4'b0010,
    ST_MERGE = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [ANGLE_BITS-1:0] yaw_r, pitch_r, roll_r;
  logic [ANGLE_BITS-1:0] yaw_nxt, pitch_nxt, roll_nxt;
  logic [ANGLE_BITS-1:0] yaw_in, pitch_in, roll_in;
  logic                  in_acc;
  logic [2:0]            lane_done;
  sincos_t               lane_sc [3];
  logic                  merge_done;
  logic [143:0]          axes;
  logic [143:0]          out_data_r;
  logic                  out_valid_r;
  logic                  out_free;

  assign yaw_in   = ANGLE_BITS'(signed'(in_tdata[15:0]));
  assign pitch_in = ANGLE_BITS'(signed'(in_tdata[31:16]));
  assign roll_in  = ANGLE_BITS'(signed'(in_tdata[47:32]));

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    if (in_tuser) begin
      yaw_nxt   = yaw_r + yaw_in;
      pitch_nxt = pitch_r + pitch_in;
      roll_nxt  = roll_r + roll_in;
    end else begin
      yaw_nxt   = yaw_in;
      pitch_nxt = pitch_in;
      roll_nxt  = roll_in;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_CORD;
      ST_CORD:  if (lane_done[0]) state_nxt = ST_MERGE;
      ST_MERGE: if (merge_done) state_nxt = out_free ? ST_IDLE : ST_HOLD;
      ST_HOLD:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      yaw_r       <= '0;
      pitch_r     <= '0;
      roll_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        yaw_r   <= yaw_nxt;
        pitch_r <= pitch_nxt;
        roll_r  <= roll_nxt;
      end
      if (out_free && ((state_r == ST_MERGE && merge_done) || state_r == ST_HOLD)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && ((state_r == ST_MERGE && merge_done) || state_r == ST_HOLD)) begin
      out_data_r <= axes;
    end
  end

  eal_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk(clk), .rst_n(rst_n), .start(in_acc), .angle(yaw_nxt),
    .done(lane_done[0]), .sc(lane_sc[0])
  );

  eal_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk(clk), .rst_n(rst_n), .start(in_acc), .angle(pitch_nxt),
    .done(lane_done[1]), .sc(lane_sc[1])
  );

  eal_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk(clk), .rst_n(rst_n), .start(in_acc), .angle(roll_nxt),
    .done(lane_done[2]), .sc(lane_sc[2])
  );

  eal_merge #(.AXIS_FRAC_BITS(AXIS_FRAC_BITS)) u_merge (
    .clk(clk), .rst_n(rst_n), .start(lane_done[0]),
    .yaw_sc(lane_sc[0]), .pitch_sc(lane_sc[1]), .roll_sc(lane_sc[2]),
    .done(merge_done), .axes(axes)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `EAL_ASSERT_NEXT(a_accept_busy, in_acc, !in_tready, "request accepted while busy")
  `EAL_ASSERT_NOW(a_lanes_sync, lane_done[0] || lane_done[1] || lane_done[2], lane_done == 3'b111, "lanes out of step")
  `EAL_ASSERT_NOW(a_merge_state, merge_done, state_r == ST_MERGE, "merge finished outside merge state")
  `EAL_ASSERT_NOW(a_cord_state, lane_done[0], state_r == ST_CORD, "lanes finished outside cordic state")

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

class axes_scoreboard;
  logic [143:0] axes_q[$];
  logic [15:0] yaw, pitch, roll;
  int mismatches;
  int checked;

  function new();
    yaw = '0;
    pitch = '0;
    roll = '0;
    mismatches = 0;
    checked = 0;
  endfunction

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void sincos(logic [15:0] a, output longint sn, output longint cs);
    logic [31:0] t;
    longint x, y, z, dx, dy;
    longint atan_tab[30];
    atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                 10679838, 5340245, 2670163, 1335087, 667544, 333772,
                 166886, 83443, 41722, 20861, 10430, 5215,
                 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};
    t = {a, 16'h0};
    x = 652032874;
    y = 0;
    z = longint'(t[29:0]);
    for (int i = 0; i < 30; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    case (t[31:30])
      2'd0: begin cs = x; sn = y; end
      2'd1: begin cs = -y; sn = x; end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
  endfunction

  function automatic longint mq(longint a, longint b);
    return fshr(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic logic [15:0] to_axis(longint v);
    longint r;
    r = fshr(v + (64'sd1 <<< 15), 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function void note_request(bit delta, logic [15:0] y, logic [15:0] p, logic [15:0] r);
    longint sy, cy, sp, cp, sr, cr, spsr, spcr;
    logic [143:0] v;
    if (delta) begin
      yaw += y; pitch += p; roll += r;
    end else begin
      yaw = y; pitch = p; roll = r;
    end
    sincos(yaw, sy, cy);
    sincos(pitch, sp, cp);
    sincos(roll, sr, cr);
    spsr = mq(sp, sr);
    spcr = mq(sp, cr);
    v[15:0] = to_axis(mq(cy, cr) + mq(sy, spsr));
    v[31:16] = to_axis(mq(cp, sr));
    v[47:32] = to_axis(-mq(sy, cr) + mq(cy, spsr));
    v[63:48] = to_axis(-mq(cy, sr) + mq(sy, spcr));
    v[79:64] = to_axis(mq(cp, cr));
    v[95:80] = to_axis(mq(sy, sr) + mq(cy, spcr));
    v[111:96] = to_axis(mq(sy, cp));
    v[127:112] = to_axis(-sp);
    v[143:128] = to_axis(mq(cy, cp));
    axes_q.push_back(v);
  endfunction

  function void check_axes(logic [143:0] got);
    logic [143:0] want;
    bit bad;
    if (axes_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = axes_q.pop_front();
    checked++;
    bad = 0;
    for (int f = 0; f < 9; f++)
      if (got[f*16 +: 16] !== want[f*16 +: 16]) bad = 1;
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch: expected %h got %h", want, got);
    end
  endfunction
endclass

module tb;
  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [47:0] in_tdata = 0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [143:0] out_tdata;

  axes_scoreboard sb = new();
  int idle_cycles = 0;
  int sent = 0;
  int deltas = 0;
  bit done_sending = 0;

  always #5 clk = ~clk;

  euler_angles_to_local_axes uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_request(in_tuser, in_tdata[15:0], in_tdata[31:16], in_tdata[47:32]);
      if (out_tvalid && out_tready)
        sb.check_axes(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // stall pattern: long free stretches, then bursts of random backpressure
  always @(posedge clk) begin
    int ph;
    ph = ($time / 10) % 400;
    if (ph < 120) out_tready <= 1;
    else if (ph < 200) out_tready <= ($urandom_range(0, 3) == 0);
    else out_tready <= $urandom_range(0, 1);
  end

  always @(posedge clk) begin
    if (idle_cycles > 5000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send(bit cmd, logic [15:0] y, logic [15:0] p, logic [15:0] r);
    in_tvalid <= 1;
    in_tuser <= cmd;
    in_tdata <= {r, p, y};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    if (cmd) deltas++;
  endtask

  task automatic pause(int n);
    in_tvalid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic random_request();
    logic [15:0] y, p, r;
    bit cmd;
    cmd = 1'($urandom_range(0, 1));
    y = 16'($urandom); p = 16'($urandom); r = 16'($urandom);
    case ($urandom_range(0, 5))
      0: begin
        y = {2'($urandom_range(0, 3)), 14'h0};
        p = {2'($urandom_range(0, 3)), 14'h0};
      end
      1: begin
        y = 16'($urandom_range(0, 7)) - 16'd4;
        r = 16'($urandom_range(0, 7)) - 16'd4;
      end
      default: ;
    endcase
    send(cmd, y, p, r);
  endtask

  initial begin
    logic [15:0] ext[6];
    ext = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff, 16'h4000, 16'hc000};
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send(1'b1, 16'h0, 16'h0, 16'h0);
    for (int i = 0; i < 6; i++) send(1'b0, ext[i], ext[(i + 2) % 6], ext[(i + 4) % 6]);
    send(1'b0, 16'h2000, 16'h4000, 16'h6000);
    send(1'b1, 16'h0, 16'h0, 16'h0);
    send(1'b1, 16'h7fff, 16'h8000, 16'hffff);
    send(1'b1, 16'h8000, 16'h7fff, 16'h0001);
    send(1'b0, 16'h0001, 16'hffff, 16'h5555);
    send(1'b1, 16'haaaa, 16'h5555, 16'haaaa);
    pause(1);
    // hold until every outstanding request has drained
    while (sb.axes_q.size() != 0) @(posedge clk);
    for (int n = 0; n < 600; n++) begin
      if ($urandom_range(0, 7) == 0) pause($urandom_range(1, 60));
      random_request();
      if (n == 300) begin
        pause(1);
        while (sb.axes_q.size() != 0) @(posedge clk);
      end
    end
    pause(1);
    while (sb.axes_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d requests (%0d delta updates), checked %0d axis sets.",
             sent, deltas, sb.checked);
    $display("Covered angle extremes, quadrant boundaries and wrapping deltas.");
    if (sb.mismatches == 0 && sb.axes_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

// ----- euler_angles_to_local_axes.f -----
+incdir+hw/rtl
hw/rtl/eal_pkg.sv
hw/rtl/eal_cordic.sv
hw/rtl/eal_merge.sv
hw/rtl/euler_angles_to_local_axes.sv
verif/tb.sv
